// File: rtl/core/assert_macros.svh
// Assertion macros shared by the ring buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: expected follow-up missing");

`endif

// File: rtl/core/urtf_pkg.sv
// Package: types and defaults for the UART receive/transmit ring buffer.
`default_nettype none

package urtf_pkg;

  localparam int RX_DEPTH_DEF = 16;
  localparam int TX_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    ACT_RX_BYTE   = 2'd0,
    ACT_HOST_READ = 2'd1,
    ACT_HOST_ADD  = 2'd2,
    ACT_TX_DONE   = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data_byte;
    logic       tx_register_empty;
  } evt_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       accepted;
    logic       rx_is_empty;
    logic       rx_is_full;
    logic       rx_lost;
    logic       tx_is_empty;
    logic       tx_is_full;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/urtf_chan_if.sv
// Interface: valid/ready channel carrying one word of a given payload type.
`default_nettype none

interface urtf_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/urtf_ring.sv
// Byte ring: memory with head/tail pointers and empty/full flags.
`default_nettype none
`include "assert_macros.svh"

module urtf_ring import urtf_pkg::*; #(
  parameter int DEPTH = RX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] wdata,
  input  logic       pop,
  output logic [7:0] rdata,
  output ring_stat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic          empty;
  logic          full;
  logic          do_push;
  logic          do_pop;

  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_next = (head == LAST) ? '0 : head + 1'b1;
  assign tail_next = (tail == LAST) ? '0 : tail + 1'b1;
  assign stat      = '{empty: empty, full: full};

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= wdata;
    end
    if (do_pop) begin
      rdata <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
      full  <= 1'b0;
    end else if (do_push) begin
      tail  <= tail_next;
      empty <= 1'b0;
      full  <= (tail_next == head);
    end else if (do_pop) begin
      head  <= head_next;
      full  <= 1'b0;
      empty <= (head_next == tail);
    end
  end

  `ASSERT_NEVER(a_full_and_empty, clk, rst, full && empty)
  `ASSERT_NEXT(a_push_not_empty, clk, rst, do_push, !empty)
  `ASSERT_NEXT(a_pop_not_full, clk, rst, do_pop, !full)

endmodule

`default_nettype wire

// File: rtl/core/uart_rx_tx_ring_fifo.sv
// Top level: UART receive and transmit ring buffers with event handshake.
`default_nettype none
`include "assert_macros.svh"

// One event word is taken per cycle on evt unless stage 1 is stalled; each
// yields exactly one result word on res via stage 1 and the result register.
// Stage 1 updates pointers and flags and does the single memory access of
// the ring involved (write at tail or registered read at head); the result
// register takes that read data and lets a new event in while a finished word
// waits. Receive bytes arriving while the rx ring is full are dropped and set
// a sticky lost flag; a tx add to an empty ring with a free transmit register
// bypasses the ring. Reset empties both rings; no clearing pass is needed.
module uart_rx_tx_ring_fifo import urtf_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  urtf_chan_if.sink   evt,
  urtf_chan_if.source res
);

  ring_stat_t rx_stat;
  ring_stat_t tx_stat;
  logic [7:0] rx_rdata;
  logic [7:0] tx_rdata;

  logic       fire;
  logic       rx_push;
  logic       rx_pop;
  logic       tx_push;
  logic       tx_pop;
  logic       bypass;
  logic       take;
  logic       read_hit;
  logic       ring_send;

  logic       lost;
  logic       s1_valid;
  action_t    s1_action;
  logic [7:0] s1_byte;
  logic       s1_read_hit;
  logic       s1_ring_send;
  logic       s1_bypass;
  logic       s1_accepted;
  logic       s1_move;
  logic       res_valid;
  res_t       res_data;

  assign s1_move   = !res_valid || res.ready;
  assign evt.ready = !s1_valid || s1_move;
  assign fire      = evt.valid && evt.ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  always_comb begin
    bypass    = 1'b0;
    take      = 1'b0;
    read_hit  = 1'b0;
    ring_send = 1'b0;
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    tx_push   = 1'b0;
    tx_pop    = 1'b0;
    unique case (evt.data.action)
      ACT_RX_BYTE: begin
        rx_push = fire;
      end
      ACT_HOST_READ: begin
        rx_pop   = fire;
        read_hit = !rx_stat.empty;
      end
      ACT_HOST_ADD: begin
        bypass  = tx_stat.empty && evt.data.tx_register_empty;
        take    = bypass || !tx_stat.full;
        tx_push = fire && !bypass;
      end
      ACT_TX_DONE: begin
        tx_pop    = fire;
        ring_send = !tx_stat.empty;
      end
      default: begin
      end
    endcase
  end

  urtf_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .push  (rx_push),
    .wdata (evt.data.data_byte),
    .pop   (rx_pop),
    .rdata (rx_rdata),
    .stat  (rx_stat)
  );

  urtf_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .push  (tx_push),
    .wdata (evt.data.data_byte),
    .pop   (tx_pop),
    .rdata (tx_rdata),
    .stat  (tx_stat)
  );

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_action    <= evt.data.action;
      s1_byte      <= evt.data.data_byte;
      s1_read_hit  <= read_hit;
      s1_ring_send <= ring_send;
      s1_bypass    <= bypass;
      s1_accepted  <= take && (evt.data.action == ACT_HOST_ADD);
    end
  end

  // ring flags at move time already reflect the step held in stage 1
  always_ff @(posedge clk) begin
    if (s1_valid && s1_move) begin
      res_data.read_data   <= s1_read_hit ? rx_rdata : 8'd0;
      res_data.send_valid  <= s1_bypass || s1_ring_send;
      res_data.send_byte   <= s1_bypass ? s1_byte : (s1_ring_send ? tx_rdata : 8'd0);
      res_data.accepted    <= s1_accepted;
      res_data.rx_is_empty <= rx_stat.empty;
      res_data.rx_is_full  <= rx_stat.full;
      res_data.rx_lost     <= lost;
      res_data.tx_is_empty <= tx_stat.empty;
      res_data.tx_is_full  <= tx_stat.full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lost      <= 1'b0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rx_push && rx_stat.full) begin
        lost <= 1'b1;
      end
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_move) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_no_overrun, clk, rst, s1_valid && !s1_move && evt.ready)
  `ASSERT_NEVER(a_accept_only_add, clk, rst, s1_valid && s1_accepted && s1_action != ACT_HOST_ADD)
  `ASSERT_NEXT(a_lost_sticky, clk, rst, lost, lost)

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for uart_rx_tx_ring_fifo: random event words checked against a ring predictor.
`timescale 1ns / 100ps

module tb;
  import urtf_pkg::*;

  localparam int RX_N = RX_DEPTH_DEF;
  localparam int TX_N = TX_DEPTH_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int ITEMS_PER_PHASE = 210;

  logic clk = 1'b0;
  logic rst;

  urtf_chan_if #(.payload_t(evt_t)) evt_ch ();
  urtf_chan_if #(.payload_t(res_t)) res_ch ();

  uart_rx_tx_ring_fifo #(
    .RX_DEPTH(RX_N),
    .TX_DEPTH(TX_N)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .evt(evt_ch),
    .res(res_ch)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [7:0] rx_mem [RX_N];
  logic [7:0] tx_mem [TX_N];
  int rx_rd, rx_wr, tx_rd, tx_wr;
  logic rx_empty, rx_full, rx_dropped, tx_empty, tx_full;

  evt_t event_queue[$];
  res_t pending_results[$];

  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  bit evt_taken = 0;

  function automatic int ring_next(int p, int depth);
    return (p == depth - 1) ? 0 : p + 1;
  endfunction

  function automatic res_t ring_step(evt_t ev);
    res_t r;
    r = '0;
    case (ev.action)
      ACT_RX_BYTE: begin
        if (rx_full) begin
          rx_dropped = 1'b1;
        end else begin
          rx_mem[rx_wr] = ev.data_byte;
          rx_empty = 1'b0;
          rx_wr = ring_next(rx_wr, RX_N);
          if (rx_wr == rx_rd) rx_full = 1'b1;
        end
      end
      ACT_HOST_READ: begin
        if (!rx_empty) begin
          r.read_data = rx_mem[rx_rd];
          rx_full = 1'b0;
          rx_rd = ring_next(rx_rd, RX_N);
          if (rx_rd == rx_wr) rx_empty = 1'b1;
        end
      end
      ACT_HOST_ADD: begin
        if (tx_empty && ev.tx_register_empty) begin
          // straight to the transmit register, ring untouched
          r.send_valid = 1'b1;
          r.send_byte = ev.data_byte;
          r.accepted = 1'b1;
        end else if (!tx_full) begin
          tx_mem[tx_wr] = ev.data_byte;
          tx_empty = 1'b0;
          tx_wr = ring_next(tx_wr, TX_N);
          if (tx_wr == tx_rd) tx_full = 1'b1;
          r.accepted = 1'b1;
        end
      end
      default: begin
        if (!tx_empty) begin
          r.send_valid = 1'b1;
          r.send_byte = tx_mem[tx_rd];
          tx_full = 1'b0;
          tx_rd = ring_next(tx_rd, TX_N);
          if (tx_rd == tx_wr) tx_empty = 1'b1;
        end
      end
    endcase
    r.rx_is_empty = rx_empty;
    r.rx_is_full = rx_full;
    r.rx_lost = rx_dropped;
    r.tx_is_empty = tx_empty;
    r.tx_is_full = tx_full;
    return r;
  endfunction

  task automatic cmp_field(string fname, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", fname, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic push_evt(action_t a, logic [7:0] d, logic reg_free);
    evt_t ev;
    ev.action = a;
    ev.data_byte = d;
    ev.tx_register_empty = reg_free;
    event_queue.push_back(ev);
  endtask

  // burst modes lean toward one action so the rings fill, wrap and drain
  task automatic push_random(int mode);
    int pick;
    action_t a;
    pick = $urandom_range(99);
    if (mode == 4 || pick >= 75) a = action_t'($urandom_range(3));
    else a = action_t'(mode);
    // tx fill mostly with a busy register so words queue up
    if (mode == ACT_HOST_ADD)
      push_evt(a, 8'($urandom_range(255)), $urandom_range(99) < 20);
    else
      push_evt(a, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // driver: offers the next word at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      evt_ch.valid <= 1'b0;
    end else if (!evt_ch.valid || evt_taken) begin
      if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        evt_ch.valid <= 1'b1;
        evt_ch.data <= event_queue.pop_front();
      end else begin
        evt_ch.valid <= 1'b0;
      end
    end
  end

  // result side ready, with an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left = LONG_HOLD;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predicts on accepted events, checks accepted results, watchdog
  always @(posedge clk) begin
    res_t got, want;
    evt_taken = 0;
    if (!rst) begin
      if (evt_ch.valid && evt_ch.ready) begin
        evt_taken = 1;
        pending_results.push_back(ring_step(evt_ch.data));
      end
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: 0x%0h", got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          cmp_field("read_data", want.read_data, got.read_data);
          cmp_field("send_valid", want.send_valid, got.send_valid);
          cmp_field("send_byte", want.send_byte, got.send_byte);
          cmp_field("accepted", want.accepted, got.accepted);
          cmp_field("rx_is_empty", want.rx_is_empty, got.rx_is_empty);
          cmp_field("rx_is_full", want.rx_is_full, got.rx_is_full);
          cmp_field("rx_lost", want.rx_lost, got.rx_lost);
          cmp_field("tx_is_empty", want.tx_is_empty, got.tx_is_empty);
          cmp_field("tx_is_full", want.tx_is_full, got.tx_is_full);
        end
      end
      if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    int mode;
    int burst;
    int n;
    rst = 1'b1;
    evt_ch.valid = 1'b0;
    evt_ch.data = '0;
    res_ch.ready = 1'b0;
    rx_rd = 0; rx_wr = 0; tx_rd = 0; tx_wr = 0;
    rx_empty = 1'b1; rx_full = 1'b0; rx_dropped = 1'b0;
    tx_empty = 1'b1; tx_full = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty-ring corners, extremes of the byte, bypass vs queued add
    push_evt(ACT_HOST_READ, 8'hFF, 1'b1);
    push_evt(ACT_TX_DONE, 8'hFF, 1'b1);
    push_evt(ACT_RX_BYTE, 8'hFF, 1'b0);
    push_evt(ACT_RX_BYTE, 8'h00, 1'b1);
    push_evt(ACT_RX_BYTE, 8'hA5, 1'b0);
    push_evt(ACT_HOST_READ, 8'h00, 1'b0);
    push_evt(ACT_HOST_READ, 8'h00, 1'b0);
    push_evt(ACT_HOST_READ, 8'h00, 1'b0);
    push_evt(ACT_HOST_READ, 8'h00, 1'b0);
    push_evt(ACT_HOST_ADD, 8'hFF, 1'b1);
    push_evt(ACT_HOST_ADD, 8'h00, 1'b0);
    push_evt(ACT_HOST_ADD, 8'h5A, 1'b1);
    push_evt(ACT_HOST_ADD, 8'h80, 1'b0);
    push_evt(ACT_TX_DONE, 8'h00, 1'b0);
    push_evt(ACT_TX_DONE, 8'h00, 1'b0);
    push_evt(ACT_TX_DONE, 8'h00, 1'b1);
    push_evt(ACT_TX_DONE, 8'h00, 1'b1);
    push_evt(ACT_HOST_ADD, 8'h01, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      // back-pressure test: result side stops while words keep coming
      if (phase == 0) hold_asks++;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        mode = $urandom_range(4);
        burst = $urandom_range(40, 8);
        for (int i = 0; i < burst; i++) push_random(mode);
        n += burst;
      end
      while (event_queue.size() > 0) @(posedge clk);
    end

    while (event_queue.size() > 0 || evt_ch.valid || pending_results.size() > 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
